// File: rtl/stip_pkg.sv
// Package for the streaming integer parser: parse phases, the parse state and
// result records, character codes and the digit decoder.
// No dependencies; used by stip_step and string_to_integer_parser_core.
package stip_pkg;

	// Width of the consumed-character counter; it saturates at all ones.
	localparam int OFFSET_BITS = 16;
	localparam int VALUE_BITS  = 64;
	localparam int BASE_BITS   = 6;
	localparam int CHAR_BITS   = 8;
	localparam int DIGIT_BITS  = 7;
	localparam int OUT_OFFSET_BITS = 16;

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;

	localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

	// Marks a character that is neither a decimal digit nor a letter.
	localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd99;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		phase_t                  phase;
		logic                    minus;
		logic [VALUE_BITS-1:0]   acc;
		logic [BASE_BITS-1:0]    base;
		logic [OFFSET_BITS-1:0]  count;
	} parse_state_t;

	typedef struct packed {
		logic                    emit;
		logic [VALUE_BITS-1:0]   value;
		logic [OFFSET_BITS-1:0]  count;
	} parse_result_t;

	localparam parse_state_t PARSE_CLEAR = '{
		phase: PH_SKIP,
		minus: 1'b0,
		acc:   '0,
		base:  '0,
		count: '0
	};

	function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
		logic [DIGIT_BITS-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = DIGIT_BITS'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = DIGIT_BITS'(c - CH_LA) + 7'd10;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = DIGIT_BITS'(c - CH_UA) + 7'd10;
		end
		return d;
	endfunction

endpackage

// File: rtl/stip_step.sv
// Next-state logic of the integer parser: consumes one character against the
// current parse state and gives the next state and an optional result.
// Depends on stip_pkg.
module stip_step (
	input  stip_pkg::parse_state_t                  cur,
	input  logic [stip_pkg::CHAR_BITS-1:0]          char_in,
	input  logic [stip_pkg::BASE_BITS-1:0]          base_cfg,
	output stip_pkg::parse_state_t                  nxt,
	output stip_pkg::parse_result_t                 res
);
	import stip_pkg::*;

	logic [DIGIT_BITS-1:0]            dig;
	logic [BASE_BITS-1:0]             eb;
	logic [OFFSET_BITS-1:0]           cnt_inc;
	logic [VALUE_BITS+BASE_BITS-1:0]  prod;
	logic                             prefix_path;
	logic                             use_digit;

	assign dig     = digit_of(char_in);
	assign cnt_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + 1'b1;

	always_comb begin
		nxt         = cur;
		res.emit    = 1'b0;
		res.value   = cur.minus ? (VALUE_BITS'(0) - cur.acc) : cur.acc;
		res.count   = cur.count;
		prefix_path = 1'b0;
		use_digit   = 1'b0;
		eb          = cur.base;

		case (cur.phase)
			PH_SKIP: begin
				if (char_in == CH_SPACE || char_in == CH_TAB) begin
					nxt.count = cnt_inc;
				end else if (char_in == CH_PLUS || char_in == CH_MINUS) begin
					nxt.minus = cur.minus | (char_in == CH_MINUS);
					nxt.count = cnt_inc;
					nxt.phase = PH_PREFIX;
				end else begin
					prefix_path = 1'b1;
				end
			end
			PH_PREFIX: begin
				prefix_path = 1'b1;
			end
			PH_ZERO: begin
				if (char_in == CH_LX) begin
					nxt.base  = BASE_HEX;
					nxt.count = cnt_inc;
					nxt.phase = PH_DIGITS;
				end else begin
					eb        = (cur.base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
					use_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				use_digit = 1'b1;
			end
			default: begin
				use_digit = 1'b1;
			end
		endcase

		// The base register is sampled here, when the prefix is decided.
		if (prefix_path) begin
			if ((base_cfg == BASE_AUTO || base_cfg == BASE_HEX) && char_in == CH_ZERO) begin
				nxt.base  = base_cfg;
				nxt.count = cnt_inc;
				nxt.phase = PH_ZERO;
			end else begin
				eb        = (base_cfg == BASE_AUTO) ? BASE_DEC : base_cfg;
				use_digit = 1'b1;
			end
		end

		prod = cur.acc * eb;

		if (use_digit) begin
			if (dig >= {1'b0, eb}) begin
				res.emit = 1'b1;
				nxt      = PARSE_CLEAR;
			end else begin
				nxt.acc   = prod[VALUE_BITS-1:0] + VALUE_BITS'(dig);
				nxt.base  = eb;
				nxt.count = cnt_inc;
				nxt.phase = PH_DIGITS;
			end
		end
	end

endmodule

// File: rtl/string_to_integer_parser_core.sv
// Top level of the streaming integer parser: input stage, parse state,
// result register and configuration register.
// Depends on stip_pkg and stip_step.

// The parser takes one character per transaction on the input channel and
// can accept a new character in every clock cycle unless the input stage
// stalls. Each accepted character is captured in an input register. From
// there it is applied to the parse state through one multiply-add by the
// active radix (a 64 by 6 bit product plus the digit), which is the loop that
// sets the character rate. A character that ends the number loads one result
// transaction (signed value and consumed count) into the result register at
// the same edge that clears the parse state. The result is therefore offered
// from the result register once its terminating character has been applied,
// and it is taken at an edge where the output side is ready. The terminating
// character itself is not consumed; the next character starts a new string.
// The result register sits between the two sides, so characters keep flowing
// while a result waits; only when a second result is due while the first is
// still held does the input stage stall. The radix register is written by
// its own channel, which is always ready, and it should be written only while
// no string is in progress, since its value is sampled when the prefix of a
// string is decided.
module string_to_integer_parser_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [stip_pkg::CHAR_BITS-1:0]         char_code,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [stip_pkg::VALUE_BITS-1:0] parsed_value,
	output logic [stip_pkg::OUT_OFFSET_BITS-1:0]   end_offset,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [stip_pkg::BASE_BITS-1:0]         number_base
);
	import stip_pkg::*;

	// The counter is reduced to the 16-bit offset field by taking its low bits,
	// zero-extended first when it is narrower than the field.
	localparam int EXT_BITS = (OFFSET_BITS > OUT_OFFSET_BITS) ? OFFSET_BITS : OUT_OFFSET_BITS;

	logic                    valid_s1;
	logic [CHAR_BITS-1:0]    char_s1;
	logic [BASE_BITS-1:0]    base_q;
	parse_state_t            state_q;
	parse_state_t            state_nxt;
	parse_result_t           step_res;
	logic                    out_valid_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [OUT_OFFSET_BITS-1:0] offset_q;
	logic [EXT_BITS-1:0]     count_ext;
	logic                    out_free;
	logic                    advance;

	// The character in stage one may only retire when its result, if any,
	// has a free slot in the result register.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!step_res.emit || out_free);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	stip_step u_step (
		.cur      (state_q),
		.char_in  (char_s1),
		.base_cfg (base_q),
		.nxt      (state_nxt),
		.res      (step_res)
	);

	assign count_ext = EXT_BITS'(step_res.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_AUTO;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= number_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			value_q  <= step_res.value;
			offset_q <= count_ext[OUT_OFFSET_BITS-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = $signed(value_q);
	assign end_offset   = offset_q;

	// A finished number always leaves a cleared parse behind.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.emit) |=>
			(state_q.phase == PH_SKIP && state_q.count == '0 && state_q.acc == '0))
		else $error("parse state not cleared after a result");

	// Within one string the consumed count never goes down.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !step_res.emit) |=> (state_q.count >= $past(state_q.count)))
		else $error("consumed count decreased within a string");

	// A character held back by a full result register stays in stage one.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1)))
		else $error("stalled character lost from stage one");

	// A waiting result is never overwritten by a new one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(advance && step_res.emit))
		else $error("result register overwritten while held");

endmodule
